@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define QE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define QE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define QE_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/qenc_pkg.sv @@
// Shared types, constants and the transition table of the encoder block.
package qenc_pkg;

    localparam int COUNTS_PER_DETENT = 4;
    localparam int TIME_BITS         = 32;
    localparam int CNT_W             = 4;
    localparam int DEB_W             = 8;
    localparam int CFG_IDX_W         = 1;

    localparam logic [DEB_W-1:0] DEBOUNCE_RST = DEB_W'(40);

    localparam logic signed [CNT_W-1:0] CNT_MAX = CNT_W'(COUNTS_PER_DETENT);
    localparam logic signed [CNT_W-1:0] CNT_MIN = CNT_W'(-COUNTS_PER_DETENT);

    localparam logic signed [1:0] ROT_NONE = 2'sd0;
    localparam logic signed [1:0] ROT_CW   = 2'sd1;
    localparam logic signed [1:0] ROT_CCW  = -2'sd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_MS    = 1'b0,
        CFG_BUTTON_PRESENT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic                 phase_a;
        logic                 phase_b;
        logic                 button_level;
        logic [TIME_BITS-1:0] now_ms;
    } t_sample;

    typedef struct packed {
        logic [1:0]              last_phase;
        logic signed [CNT_W-1:0] sub_count;
        logic                    last_button;
        logic [TIME_BITS-1:0]    last_change;
    } t_state;

    typedef struct packed {
        logic [DEB_W-1:0] debounce_ms;
        logic             button_present;
    } t_cfg;

    typedef struct packed {
        logic signed [1:0] rotation;
        logic              clicked;
    } t_result;

    // Gray-code step for {old pair, new pair}; illegal double changes give 0.
    function automatic logic signed [1:0] step_lookup(input logic [3:0] idx);
        logic signed [1:0] step;
        case (idx)
            4'b0001, 4'b0111, 4'b1000, 4'b1110: step = ROT_CCW;
            4'b0010, 4'b0100, 4'b1011, 4'b1101: step = ROT_CW;
            default:                            step = ROT_NONE;
        endcase
        return step;
    endfunction

endpackage

@@ rtl/quadrature_encoder_with_button_core.sv @@
// Quadrature rotary encoder decoder with a debounced push button.
//
// Every sample item (phase_a, phase_b, button_level, now_ms) produces exactly
// one result item (rotation, clicked). A change of the phase pair steps a
// sub-detent counter through a Gray-code table; at +/-4 counts one detent is
// reported (rotation 1 clockwise, -1 counter-clockwise) and the counter
// clears. Double phase changes are illegal and add nothing, but the new pair
// is still recorded. With button_present set, a button level change is taken
// only when more than debounce_ms has elapsed (wrapping difference) since the
// last taken change; a taken falling edge reports clicked. Throughput is one
// item per clock while the output is not stalled: a sample lands in an input
// register, one pass of table lookup, add and compare moves it into the
// output register, and the next sample is taken in the same cycle. o_stall
// rises only when both registers are full and the output is stalled. The
// user must write configuration (index 0 debounce_ms, index 1 button_present)
// only while the block is idle; the block does not enforce this. Reset loads
// 40 and 1.
module quadrature_encoder_with_button_core
    import qenc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // sample channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_phase_a,
    input  logic                 i_phase_b,
    input  logic                 i_button_level,
    input  logic [31:0]          i_now_ms,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [1:0]    o_rotation,
    output logic                 o_clicked,
    // config write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DEB_W-1:0]     i_cfg_data
);

    logic    r_in_valid;
    t_sample r_in;
    t_state  r_state;
    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_out;

    t_state  n_state;
    t_result n_out;

    logic    out_free;
    logic    advance;
    logic    in_take;

    // Output slot frees up when empty or when its item leaves this cycle.
    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    qenc_step u_step (
        .i_sample (r_in),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take || advance) begin
            r_in_valid <= in_take;
        end
        if (in_take) begin
            r_in.phase_a      <= i_phase_a;
            r_in.phase_b      <= i_phase_b;
            r_in.button_level <= i_button_level;
            r_in.now_ms       <= i_now_ms[TIME_BITS-1:0];
        end
    end

    // decoder state, updated as each item passes to the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.last_phase  <= 2'b00;
            r_state.sub_count   <= '0;
            r_state.last_button <= 1'b1;
            r_state.last_change <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms    <= DEBOUNCE_RST;
            r_cfg.button_present <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_DEBOUNCE_MS:    r_cfg.debounce_ms    <= i_cfg_data;
                CFG_BUTTON_PRESENT: r_cfg.button_present <= i_cfg_data[0];
                default:            ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_rotation = r_out.rotation;
    assign o_clicked  = r_out.clicked;

endmodule

@@ rtl/qenc_step.sv @@
// Next-state and result logic for one encoder sample.
module qenc_step
    import qenc_pkg::*;
(
    input  t_sample i_sample,
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    output t_state  o_state,
    output t_result o_result
);

    logic [1:0]              cur_phase;
    logic signed [1:0]       step;
    logic signed [CNT_W-1:0] sum;
    logic [TIME_BITS-1:0]    elapsed;
    logic                    btn_take;

    assign cur_phase = {i_sample.phase_a, i_sample.phase_b};
    assign step      = step_lookup({i_state.last_phase, cur_phase});
    assign sum       = i_state.sub_count + CNT_W'(step);
    assign elapsed   = i_sample.now_ms - i_state.last_change;
    assign btn_take  = i_cfg.button_present
                    && (i_sample.button_level != i_state.last_button)
                    && (elapsed > TIME_BITS'(i_cfg.debounce_ms));

    always_comb begin
        o_state           = i_state;
        o_result.rotation = ROT_NONE;
        o_result.clicked  = 1'b0;

        if (cur_phase != i_state.last_phase) begin
            o_state.last_phase = cur_phase;
            if (sum >= CNT_MAX) begin
                o_result.rotation = ROT_CW;
                o_state.sub_count = '0;
            end else if (sum <= CNT_MIN) begin
                o_result.rotation = ROT_CCW;
                o_state.sub_count = '0;
            end else begin
                o_state.sub_count = sum;
            end
        end

        if (btn_take) begin
            o_state.last_button = i_sample.button_level;
            o_state.last_change = i_sample.now_ms;
            o_result.clicked    = !i_sample.button_level;
        end
    end

endmodule

@@ rtl/qenc_checker.sv @@
// Port-level checks for the encoder core, bound to the top level.
`include "assert_macros.svh"

module qenc_checker
    import qenc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic signed [1:0]    o_rotation,
    input logic                 o_clicked
);

    `QE_ASSERT_RST(a_rst_clears, !i_rst_n, !o_valid && !o_stall, "output valid after reset")
    `QE_ASSERT_SAME(a_stall_cause, o_stall, o_valid && i_stall, "input stalled without cause")
    `QE_ASSERT_SAME(a_rot_code, o_valid, o_rotation != 2'sb10, "illegal rotation code")
    `QE_ASSERT_NEXT(a_out_hold, o_valid && i_stall,
        o_valid && $stable(o_rotation) && $stable(o_clicked), "stalled result changed")

endmodule

bind quadrature_encoder_with_button_core qenc_checker u_qenc_checker (.*);
